>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/cic_pkg.sv
// ---------------------------------------------------------------------------
// cic_pkg
// Types, port addresses and helpers for the cascaded interrupt controller.
// ---------------------------------------------------------------------------
package cic_pkg;

   typedef enum logic [1:0] {
      CMD_IO_WRITE = 2'd0,
      CMD_IO_READ  = 2'd1,
      CMD_RAISE    = 2'd2,
      CMD_ACK      = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      INIT_IDLE = 2'd0,
      INIT_ICW2 = 2'd1,
      INIT_ICW3 = 2'd2,
      INIT_ICW4 = 2'd3
   } init_step_type;

   localparam logic [15:0] PORT_MASTER_CMD  = 16'h0020;
   localparam logic [15:0] PORT_MASTER_DATA = 16'h0021;
   localparam logic [15:0] PORT_SLAVE_CMD   = 16'h00A0;
   localparam logic [15:0] PORT_SLAVE_DATA  = 16'h00A1;

   localparam logic [7:0] MASK_RESET   = 8'hFF;
   localparam int unsigned ICW1_BIT    = 4;
   localparam int unsigned OCW3_BIT    = 3;
   localparam int unsigned OCW2_EOI_BIT = 5;
   localparam int unsigned OCW2_SL_BIT = 6;
   localparam int unsigned OCW3_RR_BIT = 1;
   localparam int unsigned OCW3_RIS_BIT = 0;
   localparam int unsigned ICW1_IC4_BIT = 0;
   localparam int unsigned ICW1_SNGL_BIT = 1;

   localparam logic [2:0] CASCADE_LINE = 3'd2;
   localparam logic [3:0] NO_LINE      = 4'd8;

   // Lowest set bit, NO_LINE when empty
   function automatic logic [3:0] lowest_bit(input logic [7:0] v);
      logic [3:0] r;
      r = NO_LINE;
      for (int i = 7; i >= 0; i--) begin
         if (v[i]) begin
            r = 4'(i);
         end
      end
      return r;
   endfunction

endpackage

>>> rtl/core/cascaded_interrupt_controller_top.sv
// ---------------------------------------------------------------------------
// cascaded_interrupt_controller_top
// Master/slave pair of 8259-style interrupt controllers behind one command
// stream: I/O writes and reads, request raising and interrupt acknowledge.
// ---------------------------------------------------------------------------
// The request register holds an accepted request; its result is then registered
// in the response register, which drives the response outputs.
// Throughput: one transfer per cycle while rsp_ready allows; the request register
// and the response register each hold one item, so stalls on rsp_ready back up one stage.
// Reset (synchronous): masks 0xFF, all other chip state zero, pipeline empty.
`include "assert_macros.svh"

module cascaded_interrupt_controller_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [15:0] req_port,
   input  logic [7:0]  req_data_value,
   input  logic [3:0]  req_irq_line,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_status,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_ack_valid,
   output logic [7:0]  rsp_vector
);

   // request stage
   logic              in_valid_ff;
   cic_pkg::cmd_type  cmd_ff;
   logic [15:0]       port_ff;
   logic [7:0]        data_ff;
   logic [3:0]        line_ff;

   // response stage
   logic              out_valid_ff;
   logic              status_ff, status_in;
   logic [7:0]        read_data_ff, read_data_in;
   logic              ack_valid_ff, ack_valid_in;
   logic [7:0]        vector_ff, vector_in;

   // chip state, index 0 master, 1 slave
   logic [7:0]                  mask_ff [2];
   logic [7:0]                  mask_in [2];
   logic [7:0]                  irr_ff [2];
   logic [7:0]                  irr_in [2];
   logic [7:0]                  isr_ff [2];
   logic [7:0]                  isr_in [2];
   logic [7:0]                  base_ff [2];
   logic [7:0]                  base_in [2];
   cic_pkg::init_step_type      step_ff [2];
   cic_pkg::init_step_type      step_in [2];
   logic [1:0]                  icw4_ff, icw4_in;
   logic [1:0]                  casc_ff, casc_in;
   logic [1:0]                  ris_ff, ris_in;

   logic advance;
   logic port_hit;
   logic chip;
   logic is_cmd_port;

   // acknowledge
   logic [7:0] mp, sp, eff;
   logic [3:0] win, isr0_low, isr1_low, sj;
   logic       deliver, cascade;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign rsp_valid     = out_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_read_data = read_data_ff;
   assign rsp_ack_valid = ack_valid_ff;
   assign rsp_vector    = vector_ff;

   always_comb begin
      port_hit    = 1'b1;
      chip        = 1'b0;
      is_cmd_port = 1'b0;
      case (port_ff)
         cic_pkg::PORT_MASTER_CMD: begin
            is_cmd_port = 1'b1;
         end
         cic_pkg::PORT_MASTER_DATA: begin
            is_cmd_port = 1'b0;
         end
         cic_pkg::PORT_SLAVE_CMD: begin
            chip        = 1'b1;
            is_cmd_port = 1'b1;
         end
         cic_pkg::PORT_SLAVE_DATA: begin
            chip = 1'b1;
         end
         default: begin
            port_hit = 1'b0;
         end
      endcase
   end

   always_comb begin
      mp       = irr_ff[0] & ~mask_ff[0];
      sp       = irr_ff[1] & ~mask_ff[1];
      eff      = mp;
      if ((sp != 8'd0) && !mask_ff[0][cic_pkg::CASCADE_LINE]) begin
         eff[cic_pkg::CASCADE_LINE] = 1'b1;
      end
      win      = cic_pkg::lowest_bit(eff);
      isr0_low = cic_pkg::lowest_bit(isr_ff[0]);
      isr1_low = cic_pkg::lowest_bit(isr_ff[1]);
      sj       = cic_pkg::lowest_bit(sp);
      deliver  = (win != cic_pkg::NO_LINE) && (win < isr0_low);
      cascade  = (win == {1'b0, cic_pkg::CASCADE_LINE}) && (sp != 8'd0) && (sj < isr1_low);
   end

   always_comb begin
      mask_in      = mask_ff;
      irr_in       = irr_ff;
      isr_in       = isr_ff;
      base_in      = base_ff;
      step_in      = step_ff;
      icw4_in      = icw4_ff;
      casc_in      = casc_ff;
      ris_in       = ris_ff;
      status_in    = 1'b0;
      read_data_in = 8'd0;
      ack_valid_in = 1'b0;
      vector_in    = 8'd0;
      case (cmd_ff)
         cic_pkg::CMD_IO_WRITE: begin
            if (!port_hit) begin
               status_in = 1'b1;
            end else if (is_cmd_port) begin
               if (data_ff[cic_pkg::ICW1_BIT]) begin
                  icw4_in[chip] = data_ff[cic_pkg::ICW1_IC4_BIT];
                  casc_in[chip] = !data_ff[cic_pkg::ICW1_SNGL_BIT];
                  step_in[chip] = cic_pkg::INIT_ICW2;
                  mask_in[chip] = 8'd0;
                  irr_in[chip]  = 8'd0;
                  isr_in[chip]  = 8'd0;
               end else if (data_ff[cic_pkg::OCW3_BIT]) begin
                  if (data_ff[cic_pkg::OCW3_RR_BIT]) begin
                     ris_in[chip] = data_ff[cic_pkg::OCW3_RIS_BIT];
                  end
               end else if (data_ff[cic_pkg::OCW2_EOI_BIT]) begin
                  if (data_ff[cic_pkg::OCW2_SL_BIT]) begin
                     isr_in[chip][data_ff[2:0]] = 1'b0;
                  end else begin
                     // clear lowest set bit
                     isr_in[chip] = isr_ff[chip] & (isr_ff[chip] - 8'd1);
                  end
               end
            end else begin
               case (step_ff[chip])
                  cic_pkg::INIT_ICW2: begin
                     base_in[chip] = data_ff;
                     step_in[chip] = casc_ff[chip] ? cic_pkg::INIT_ICW3 :
                                     icw4_ff[chip] ? cic_pkg::INIT_ICW4 :
                                                     cic_pkg::INIT_IDLE;
                  end
                  cic_pkg::INIT_ICW3: begin
                     step_in[chip] = icw4_ff[chip] ? cic_pkg::INIT_ICW4 :
                                                     cic_pkg::INIT_IDLE;
                  end
                  cic_pkg::INIT_ICW4: begin
                     step_in[chip] = cic_pkg::INIT_IDLE;
                  end
                  default: begin
                     mask_in[chip] = data_ff;
                  end
               endcase
            end
         end
         cic_pkg::CMD_IO_READ: begin
            if (!port_hit) begin
               status_in = 1'b1;
            end else if (is_cmd_port) begin
               read_data_in = ris_ff[chip] ? isr_ff[chip] : irr_ff[chip];
            end else begin
               read_data_in = mask_ff[chip];
            end
         end
         cic_pkg::CMD_RAISE: begin
            irr_in[line_ff[3]][line_ff[2:0]] = 1'b1;
         end
         default: begin
            if (deliver) begin
               ack_valid_in = 1'b1;
               if (cascade) begin
                  irr_in[1][sj[2:0]]                = 1'b0;
                  isr_in[1][sj[2:0]]                = 1'b1;
                  isr_in[0][cic_pkg::CASCADE_LINE]  = 1'b1;
                  vector_in = base_ff[1] + {5'd0, sj[2:0]};
               end else begin
                  irr_in[0][win[2:0]] = 1'b0;
                  isr_in[0][win[2:0]] = 1'b1;
                  vector_in = base_ff[0] + {5'd0, win[2:0]};
               end
            end
         end
      endcase
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff  <= cic_pkg::cmd_type'(req_command);
         port_ff <= req_port;
         data_ff <= req_data_value;
         line_ff <= req_irq_line;
      end
      if (advance) begin
         status_ff    <= status_in;
         read_data_ff <= read_data_in;
         ack_valid_ff <= ack_valid_in;
         vector_ff    <= vector_in;
      end
   end

   // control and chip state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int c = 0; c < 2; c++) begin
            mask_ff[c] <= cic_pkg::MASK_RESET;
            irr_ff[c]  <= 8'd0;
            isr_ff[c]  <= 8'd0;
            base_ff[c] <= 8'd0;
            step_ff[c] <= cic_pkg::INIT_IDLE;
         end
         icw4_ff <= 2'd0;
         casc_ff <= 2'd0;
         ris_ff  <= 2'd0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            mask_ff      <= mask_in;
            irr_ff       <= irr_in;
            isr_ff       <= isr_in;
            base_ff      <= base_in;
            step_ff      <= step_in;
            icw4_ff      <= icw4_in;
            casc_ff      <= casc_in;
            ris_ff       <= ris_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   `ASSERT_CLK(a_status_excl, clock, reset, out_valid_ff |-> !(status_ff && ack_valid_ff), "status and ack_valid both set")
   `ASSERT_CLK(a_status_io_only, clock, reset, (advance && (cmd_ff == cic_pkg::CMD_RAISE || cmd_ff == cic_pkg::CMD_ACK)) |=> !status_ff, "error status on non-io transfer")
   `ASSERT_CLK(a_ack_sets_isr, clock, reset, (advance && ack_valid_in) |=> (isr_ff[0] != 8'd0), "delivered interrupt left master ISR empty")
   `ASSERT_CLK(a_held_item, clock, reset, (in_valid_ff && !advance) |=> in_valid_ff, "pending request dropped")
   `ASSERT_CLK_ALWAYS(a_reset_empty, clock, reset |=> (!in_valid_ff && !out_valid_ff), "pipeline not empty after reset")

endmodule

>>> tb/cascaded_interrupt_controller_top_test.sv
// ---------------------------------------------------------------------------
// cascaded_interrupt_controller_top_test
// Self-checking bench for the master/slave interrupt controller pair. A
// clocked driver sends bus operations from a queue, with random gaps. A
// clocked monitor takes responses under random back-pressure. Each accepted
// operation runs through a behavioural model of both chips, and every
// response is compared field by field with the oldest predicted reply.
// ---------------------------------------------------------------------------
module cascaded_interrupt_controller_top_test;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic       status;
      logic [7:0] read_data;
      logic       ack_valid;
      logic [7:0] vector;
   } pic_reply_type;

   typedef struct {
      cic_pkg::cmd_type command;
      logic [15:0]      port;
      logic [7:0]       data_value;
      logic [3:0]       irq_line;
      bit               hold;        // wait for all replies before sending
   } bus_op_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command = '0;
   logic [15:0] req_port = '0;
   logic [7:0]  req_data_value = '0;
   logic [3:0]  req_irq_line = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_status;
   logic [7:0]  rsp_read_data;
   logic        rsp_ack_valid;
   logic [7:0]  rsp_vector;

   cascaded_interrupt_controller_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_port       (req_port),
      .req_data_value (req_data_value),
      .req_irq_line   (req_irq_line),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_read_data  (rsp_read_data),
      .rsp_ack_valid  (rsp_ack_valid),
      .rsp_vector     (rsp_vector)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Chip model, index 0 master, 1 slave
   // ------------------------------------------------------------------
   logic [7:0]             chip_mask [2];
   logic [7:0]             chip_irr  [2];
   logic [7:0]             chip_isr  [2];
   logic [7:0]             chip_base [2];
   cic_pkg::init_step_type chip_step [2];
   logic                   chip_ic4  [2];
   logic                   chip_casc [2];
   logic                   chip_ris  [2];

   function automatic logic [3:0] first_set(input logic [7:0] v);
      logic [3:0] idx;
      bit         found;
      idx = cic_pkg::NO_LINE;
      found = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (!found && v[i]) begin
            idx = 4'(i);
            found = 1'b1;
         end
      end
      return idx;
   endfunction

   function automatic void chip_model_reset();
      for (int c = 0; c < 2; c++) begin
         chip_mask[c] = cic_pkg::MASK_RESET;
         chip_irr[c]  = '0;
         chip_isr[c]  = '0;
         chip_base[c] = '0;
         chip_step[c] = cic_pkg::INIT_IDLE;
         chip_ic4[c]  = 1'b0;
         chip_casc[c] = 1'b0;
         chip_ris[c]  = 1'b0;
      end
   endfunction

   function automatic void chip_cmd_write(input int c, input logic [7:0] v);
      logic [3:0] line;
      if (v[cic_pkg::ICW1_BIT]) begin
         chip_ic4[c]  = v[cic_pkg::ICW1_IC4_BIT];
         chip_casc[c] = !v[cic_pkg::ICW1_SNGL_BIT];
         chip_step[c] = cic_pkg::INIT_ICW2;
         chip_mask[c] = '0;
         chip_irr[c]  = '0;
         chip_isr[c]  = '0;
      end else if (v[cic_pkg::OCW3_BIT]) begin
         if (v[cic_pkg::OCW3_RR_BIT]) begin
            chip_ris[c] = v[cic_pkg::OCW3_RIS_BIT];
         end
      end else if (v[cic_pkg::OCW2_EOI_BIT]) begin
         line = v[cic_pkg::OCW2_SL_BIT] ? {1'b0, v[2:0]} : first_set(chip_isr[c]);
         if (line != cic_pkg::NO_LINE) begin
            chip_isr[c][line[2:0]] = 1'b0;
         end
      end
   endfunction

   function automatic void chip_data_write(input int c, input logic [7:0] v);
      case (chip_step[c])
         cic_pkg::INIT_ICW2: begin
            chip_base[c] = v;
            chip_step[c] = chip_casc[c] ? cic_pkg::INIT_ICW3 :
                           (chip_ic4[c] ? cic_pkg::INIT_ICW4 : cic_pkg::INIT_IDLE);
         end
         cic_pkg::INIT_ICW3: begin
            chip_step[c] = chip_ic4[c] ? cic_pkg::INIT_ICW4 : cic_pkg::INIT_IDLE;
         end
         cic_pkg::INIT_ICW4: begin
            chip_step[c] = cic_pkg::INIT_IDLE;
         end
         default: begin
            chip_mask[c] = v;
         end
      endcase
   endfunction

   function automatic void chip_acknowledge(output logic hit, output logic [7:0] vec);
      logic [7:0] m_pend;
      logic [7:0] s_pend;
      logic [7:0] eff;
      logic [3:0] win;
      logic [3:0] sl;
      hit = 1'b0;
      vec = '0;
      m_pend = chip_irr[0] & ~chip_mask[0];
      s_pend = chip_irr[1] & ~chip_mask[1];
      eff = m_pend;
      if (s_pend != 0 && !chip_mask[0][cic_pkg::CASCADE_LINE]) begin
         eff[cic_pkg::CASCADE_LINE] = 1'b1;
      end
      win = first_set(eff);
      if (win == cic_pkg::NO_LINE || win >= first_set(chip_isr[0])) begin
         return;
      end
      hit = 1'b1;
      if (win == {1'b0, cic_pkg::CASCADE_LINE} && s_pend != 0) begin
         sl = first_set(s_pend);
         if (sl != cic_pkg::NO_LINE && sl < first_set(chip_isr[1])) begin
            chip_irr[1][sl[2:0]] = 1'b0;
            chip_isr[1][sl[2:0]] = 1'b1;
            chip_isr[0][cic_pkg::CASCADE_LINE] = 1'b1;
            vec = chip_base[1] + 8'(sl);
            return;
         end
      end
      chip_irr[0][win[2:0]] = 1'b0;
      chip_isr[0][win[2:0]] = 1'b1;
      vec = chip_base[0] + 8'(win);
   endfunction

   function automatic pic_reply_type predict_reply(input bus_op_type op);
      pic_reply_type rep;
      int            c;
      bit            is_cmd;
      bit            known;
      rep = '0;
      c = 0;
      is_cmd = 1'b0;
      known = 1'b1;
      case (op.command)
         cic_pkg::CMD_IO_WRITE, cic_pkg::CMD_IO_READ: begin
            case (op.port)
               cic_pkg::PORT_MASTER_CMD:  begin c = 0; is_cmd = 1'b1; end
               cic_pkg::PORT_MASTER_DATA: begin c = 0; is_cmd = 1'b0; end
               cic_pkg::PORT_SLAVE_CMD:   begin c = 1; is_cmd = 1'b1; end
               cic_pkg::PORT_SLAVE_DATA:  begin c = 1; is_cmd = 1'b0; end
               default:                   known = 1'b0;
            endcase
            if (!known) begin
               rep.status = 1'b1;
            end else if (op.command == cic_pkg::CMD_IO_WRITE) begin
               if (is_cmd) chip_cmd_write(c, op.data_value);
               else chip_data_write(c, op.data_value);
            end else if (is_cmd) begin
               rep.read_data = chip_ris[c] ? chip_isr[c] : chip_irr[c];
            end else begin
               rep.read_data = chip_mask[c];
            end
         end
         cic_pkg::CMD_RAISE: begin
            chip_irr[op.irq_line[3]][op.irq_line[2:0]] = 1'b1;
         end
         default: begin
            chip_acknowledge(rep.ack_valid, rep.vector);
         end
      endcase
      return rep;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   bus_op_type    op_queue [$];
   pic_reply_type reply_queue [$];
   int            n_sent;
   int            n_recv;
   int            n_total;
   int            n_errors = 0;

   function automatic int draw_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic push_op(input cic_pkg::cmd_type cmd, input logic [15:0] port,
                          input logic [7:0] data, input logic [3:0] line, input bit hold);
      bus_op_type op;
      op.command    = cmd;
      op.port       = port;
      op.data_value = data;
      op.irq_line   = line;
      op.hold       = hold;
      op_queue.push_back(op);
   endtask

   function automatic logic [7:0] sparse_mask();
      if ($urandom_range(0, 1) == 0) return 8'h00;
      return 8'($urandom) & 8'($urandom) & 8'($urandom);
   endfunction

   task automatic build_directed();
      // reset state, unknown ports, one with all-ones fields
      push_op(cic_pkg::CMD_IO_READ,  cic_pkg::PORT_MASTER_DATA, 8'h00, 4'd0, 1'b0);
      push_op(cic_pkg::CMD_IO_WRITE, 16'hFFFF, 8'hFF, 4'hF, 1'b0);
      push_op(cic_pkg::CMD_IO_READ,  16'h0000, 8'h00, 4'd0, 1'b0);
      // full init of both chips, cascade with ICW4
      push_op(cic_pkg::CMD_IO_WRITE, cic_pkg::PORT_MASTER_CMD,  8'h11, 4'd0, 1'b0);
      push_op(cic_pkg::CMD_IO_WRITE, cic_pkg::PORT_MASTER_DATA, 8'h08, 4'd0, 1'b0);
      push_op(cic_pkg::CMD_IO_WRITE, cic_pkg::PORT_MASTER_DATA, 8'h04, 4'd0, 1'b0);
      push_op(cic_pkg::CMD_IO_WRITE, cic_pkg::PORT_MASTER_DATA, 8'h01, 4'd0, 1'b0);
      push_op(cic_pkg::CMD_IO_WRITE, cic_pkg::PORT_SLAVE_CMD,   8'h11, 4'd0, 1'b0);
      push_op(cic_pkg::CMD_IO_WRITE, cic_pkg::PORT_SLAVE_DATA,  8'h70, 4'd0, 1'b0);
      push_op(cic_pkg::CMD_IO_WRITE, cic_pkg::PORT_SLAVE_DATA,  8'h02, 4'd0, 1'b0);
      push_op(cic_pkg::CMD_IO_WRITE, cic_pkg::PORT_SLAVE_DATA,  8'h01, 4'd0, 1'b0);
      push_op(cic_pkg::CMD_RAISE,    16'h0000, 8'h00, 4'd0, 1'b0);
      push_op(cic_pkg::CMD_RAISE,    16'h0000, 8'h00, 4'd15, 1'b0);
      push_op(cic_pkg::CMD_RAISE,    16'h0000, 8'h00, 4'd8, 1'b0);
      // master line 0, then blocked by nesting, then cascade
      push_op(cic_pkg::CMD_ACK,      16'h0000, 8'h00, 4'd0, 1'b0);
      push_op(cic_pkg::CMD_ACK,      16'h0000, 8'h00, 4'd0, 1'b0);
      push_op(cic_pkg::CMD_IO_WRITE, cic_pkg::PORT_MASTER_CMD,  8'h20, 4'd0, 1'b0);
      push_op(cic_pkg::CMD_ACK,      16'h0000, 8'h00, 4'd0, 1'b0);
      // specific EOI on line 2, slave still nested: plain master line 2
      push_op(cic_pkg::CMD_IO_WRITE, cic_pkg::PORT_MASTER_CMD,  8'h62, 4'd0, 1'b0);
      push_op(cic_pkg::CMD_ACK,      16'h0000, 8'h00, 4'd0, 1'b0);
      push_op(cic_pkg::CMD_IO_WRITE, cic_pkg::PORT_SLAVE_CMD,   8'h0B, 4'd0, 1'b0);
      push_op(cic_pkg::CMD_IO_READ,  cic_pkg::PORT_SLAVE_CMD,   8'h00, 4'd0, 1'b0);
      // masked raise, then single mode without ICW4 and base 0xF8
      push_op(cic_pkg::CMD_IO_WRITE, cic_pkg::PORT_MASTER_DATA, 8'hFF, 4'd0, 1'b1);
      push_op(cic_pkg::CMD_RAISE,    16'hFFFF, 8'hFF, 4'd3, 1'b0);
      push_op(cic_pkg::CMD_IO_READ,  cic_pkg::PORT_MASTER_CMD,  8'h00, 4'd0, 1'b0);
      push_op(cic_pkg::CMD_IO_WRITE, cic_pkg::PORT_MASTER_CMD,  8'h12, 4'd0, 1'b0);
      push_op(cic_pkg::CMD_IO_WRITE, cic_pkg::PORT_MASTER_DATA, 8'hF8, 4'd0, 1'b0);
      push_op(cic_pkg::CMD_RAISE,    16'h0000, 8'h00, 4'd7, 1'b0);
      push_op(cic_pkg::CMD_ACK,      16'hFFFF, 8'hFF, 4'hF, 1'b0);
   endtask

   task automatic build_random(input int total);
      int          r;
      int          chip;
      int          steps;
      logic [7:0]  v;
      logic [15:0] cmd_port;
      logic [15:0] data_port;
      logic [15:0] io_port;
      while (op_queue.size() < total) begin
         chip = $urandom_range(0, 1);
         cmd_port  = chip ? cic_pkg::PORT_SLAVE_CMD : cic_pkg::PORT_MASTER_CMD;
         data_port = chip ? cic_pkg::PORT_SLAVE_DATA : cic_pkg::PORT_MASTER_DATA;
         if ($urandom_range(0, 99) < 12) begin
            v = 8'($urandom) | 8'h10;
            push_op(cic_pkg::CMD_IO_WRITE, cmd_port, v, 4'($urandom),
                    $urandom_range(0, 149) == 0);
            steps = 1 + (v[cic_pkg::ICW1_SNGL_BIT] ? 0 : 1) + (v[cic_pkg::ICW1_IC4_BIT] ? 1 : 0);
            if ($urandom_range(0, 9) == 0) steps = $urandom_range(0, steps - 1);
            repeat (steps) begin
               push_op(cic_pkg::CMD_IO_WRITE, data_port, 8'($urandom), 4'($urandom), 1'b0);
            end
            if ($urandom_range(0, 2) != 0) begin
               push_op(cic_pkg::CMD_IO_WRITE, data_port, sparse_mask(), 4'($urandom), 1'b0);
            end
         end else begin
            repeat ($urandom_range(4, 16)) begin
               r = $urandom_range(0, 99);
               chip = $urandom_range(0, 1);
               cmd_port  = chip ? cic_pkg::PORT_SLAVE_CMD : cic_pkg::PORT_MASTER_CMD;
               data_port = chip ? cic_pkg::PORT_SLAVE_DATA : cic_pkg::PORT_MASTER_DATA;
               if (r < 30) begin
                  push_op(cic_pkg::CMD_RAISE, 16'($urandom), 8'($urandom), 4'($urandom),
                          $urandom_range(0, 149) == 0);
               end else if (r < 55) begin
                  push_op(cic_pkg::CMD_ACK, 16'($urandom), 8'($urandom), 4'($urandom),
                          $urandom_range(0, 149) == 0);
               end else if (r < 70) begin
                  v = (8'($urandom) & 8'hC7) | 8'h20;
                  push_op(cic_pkg::CMD_IO_WRITE, cmd_port, v, 4'($urandom), 1'b0);
               end else if (r < 78) begin
                  push_op(cic_pkg::CMD_IO_WRITE, data_port, sparse_mask(), 4'($urandom),
                          1'b0);
               end else if (r < 88) begin
                  io_port = $urandom_range(0, 1) ? cmd_port : data_port;
                  push_op(cic_pkg::CMD_IO_READ, io_port, 8'($urandom), 4'($urandom), 1'b0);
               end else if (r < 93) begin
                  v = (8'($urandom) & 8'hE7) | 8'h08;
                  push_op(cic_pkg::CMD_IO_WRITE, cmd_port, v, 4'($urandom), 1'b0);
               end else begin
                  // noise: near-miss or random port, ignored OCW2, any command
                  io_port = $urandom_range(0, 1) ? 16'($urandom)
                          : (cmd_port ^ (16'd1 << $urandom_range(0, 15)));
                  v = 8'($urandom);
                  if ($urandom_range(0, 1) == 0) begin
                     io_port = cmd_port;
                     v = v & 8'hC7;
                     push_op(cic_pkg::CMD_IO_WRITE, io_port, v, 4'($urandom), 1'b0);
                  end else begin
                     push_op(cic_pkg::cmd_type'($urandom_range(0, 3)), io_port, v,
                             4'($urandom), 1'b0);
                  end
               end
            end
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Driver
   // ------------------------------------------------------------------
   bus_op_type cur_op;
   bus_op_type next_op;
   bit         took;
   int         sent_now;
   int         tx_gap;
   int         tx_calm = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         tx_gap <= 0;
         n_sent <= 0;
         chip_model_reset();
      end else begin
         took = req_valid && req_ready;
         sent_now = n_sent;
         if (took) begin
            reply_queue.push_back(predict_reply(cur_op));
            sent_now = n_sent + 1;
            n_sent <= sent_now;
         end
         if (!req_valid || took) begin
            if (tx_gap != 0) begin
               req_valid <= 1'b0;
               tx_gap <= tx_gap - 1;
            end else if (op_queue.size() != 0 &&
                         (!op_queue[0].hold || sent_now == n_recv)) begin
               next_op = op_queue.pop_front();
               cur_op = next_op;
               req_valid <= 1'b1;
               req_command <= next_op.command;
               req_port <= next_op.port;
               req_data_value <= next_op.data_value;
               req_irq_line <= next_op.irq_line;
               tx_gap <= draw_gap(tx_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor
   // ------------------------------------------------------------------
   pic_reply_type rx_got;
   pic_reply_type rx_want;
   int            rx_stall;
   int            rx_calm = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_stall <= 0;
         n_recv <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_recv <= n_recv + 1;
            rx_got = {rsp_status, rsp_read_data, rsp_ack_valid, rsp_vector};
            if (reply_queue.size() == 0) begin
               n_errors++;
               if (n_errors <= 10) begin
                  $display("%0t: response with none outstanding: status=%0d rd=%02h",
                           $realtime, rx_got.status, rx_got.read_data);
                  $display("   ack=%0d vec=%02h", rx_got.ack_valid, rx_got.vector);
               end
            end else begin
               rx_want = reply_queue.pop_front();
               if (rx_got !== rx_want) begin
                  n_errors++;
                  if (n_errors <= 10) begin
                     $display("%0t: mismatch exp status=%0d rd=%02h ack=%0d vec=%02h",
                              $realtime, rx_want.status, rx_want.read_data,
                              rx_want.ack_valid, rx_want.vector);
                     $display("   got status=%0d rd=%02h ack=%0d vec=%02h",
                              rx_got.status, rx_got.read_data, rx_got.ack_valid,
                              rx_got.vector);
                  end
               end
            end
         end
         if (rx_stall != 0) begin
            rsp_ready <= 1'b0;
            rx_stall <= rx_stall - 1;
         end else begin
            rsp_ready <= 1'b1;
            rx_stall <= draw_gap(rx_calm);
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequencing and end of run
   // ------------------------------------------------------------------
   initial begin
      build_directed();
      build_random(1780);
      n_total = op_queue.size();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (n_recv < n_total) @(posedge clock);
      repeat (10) @(posedge clock);
      if (reply_queue.size() != 0) begin
         $display("%0d predicted replies never arrived", reply_queue.size());
      end
      if (n_errors == 0 && reply_queue.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Timeout: %0d sent, %0d received", n_sent, n_recv);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/cic_pkg.sv
rtl/core/cascaded_interrupt_controller_top.sv
tb/cascaded_interrupt_controller_top_test.sv
